>>> hdl/afsi_pkg.sv
// afsi_pkg: shared types and constants of the adts frame seek indexer
// used by afsi_scan and the top level; depends on nothing else

package afsi_pkg;

  // item modes
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_SEEK  = 2'd2;

  // result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_SEEK  = 1'b1;

  // adts header constants
  localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
  localparam logic [3:0]  SYNC_NIBBLE = 4'hF;
  localparam logic [12:0] HDR_LEN     = 13'd7;
  localparam logic [2:0]  HDR_LAST    = 3'd6;

  // seek and duration scaling
  localparam logic [9:0] PERMIL_MAX = 10'd1000;
  localparam int PERMIL_FULL = 1000;
  localparam int US_PER_SEC  = 1000000;

  // product widths feeding the constant dividers
  localparam int SEEK_PW = 42;
  localparam int SECS_PW = 52;

  // configuration port
  localparam int  ADDR_W             = 3;
  localparam logic REG_FRAME_DURATION = 1'b0;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [9:0] permil;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] frame_offset;
    logic [12:0] frame_length;
    logic [31:0] frame_number;
    logic [31:0] seek_offset;
    logic [31:0] total_secs;
  } out_t;

  // frame completion report from the scanner
  typedef struct packed {
    logic        done;
    logic [31:0] offset;
    logic [12:0] length;
    logic [31:0] number;
  } frame_rpt_t;

  // per-stage payload of the result pipeline
  typedef struct packed {
    logic        kind;
    logic [31:0] frame_offset;
    logic [12:0] frame_length;
    logic [31:0] frame_number;
  } pipe_t;

endpackage

>>> hdl/afsi_scan.sv
// afsi_scan: byte scanner, header window, frame skip and frame/index counters
// depends on afsi_pkg; drives the index memory write port

module afsi_scan #(
  parameter int INDEX_DEPTH  = 65536,
  parameter int INDEX_STRIDE = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic [1:0]                        mode,
  input  logic [7:0]                        data_byte,
  output afsi_pkg::frame_rpt_t              rpt,
  output logic                              idx_we,
  output logic [$clog2(INDEX_DEPTH)-1:0]    idx_waddr,
  output logic [31:0]                       idx_wdata,
  output logic [31:0]                       bytes_seen,
  output logic [31:0]                       frame_count,
  output logic [$clog2(INDEX_DEPTH+1)-1:0]  index_count
);

  localparam int AW  = $clog2(INDEX_DEPTH);
  localparam int ICW = $clog2(INDEX_DEPTH + 1);
  localparam int PW  = (INDEX_STRIDE > 1) ? $clog2(INDEX_STRIDE) : 1;

  logic [7:0]     hw [0:5];
  logic [7:0]     hw_next [0:5];
  logic [2:0]     fill, fill_next;
  logic [12:0]    skip, skip_next;
  logic [31:0]    pstart, pstart_next;
  logic [12:0]    plen, plen_next;
  logic [31:0]    bs_next, fc_next;
  logic [ICW-1:0] ic_next;
  logic [PW-1:0]  phase, phase_next;

  logic [2:0]  fill_eff;
  logic [12:0] flen;
  logic        finish;
  logic        byte_in;
  logic        clr;

  assign byte_in = take && (mode == afsi_pkg::MODE_DATA);
  assign clr     = take && (mode == afsi_pkg::MODE_CLEAR);
  assign fill_eff = (fill > afsi_pkg::HDR_LAST) ? afsi_pkg::HDR_LAST : fill;
  assign flen     = {hw[3][1:0], hw[4], hw[5][7:5]};

  // next state for one item
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hw_next[i] = hw[i];
    end
    fill_next   = fill;
    skip_next   = skip;
    pstart_next = pstart;
    plen_next   = plen;
    bs_next     = bytes_seen;
    fc_next     = frame_count;
    ic_next     = index_count;
    phase_next  = phase;
    finish      = 1'b0;
    rpt         = '0;
    idx_we      = 1'b0;
    idx_waddr   = AW'(index_count);
    idx_wdata   = pstart;

    if (byte_in) begin
      if (bytes_seen != 32'hFFFF_FFFF) begin
        bs_next = bytes_seen + 32'd1;
      end
      if (skip != 13'd0) begin
        // inside a frame body
        skip_next = skip - 13'd1;
        if (skip == 13'd1) begin
          finish = 1'b1;
        end
      end else if (fill_eff == afsi_pkg::HDR_LAST) begin
        // window complete with this byte: check the header
        if (hw[0] != afsi_pkg::SYNC_BYTE || hw[1][7:4] != afsi_pkg::SYNC_NIBBLE ||
            flen < afsi_pkg::HDR_LEN) begin
          for (int i = 0; i < 5; i++) begin
            hw_next[i] = hw[i+1];
          end
          hw_next[5] = data_byte;
          fill_next  = afsi_pkg::HDR_LAST;
        end else begin
          pstart_next = (bytes_seen >= 32'd6) ? bytes_seen - 32'd6 : 32'd0;
          plen_next   = flen;
          skip_next   = flen - afsi_pkg::HDR_LEN;
          fill_next   = 3'd7;
          if (flen == afsi_pkg::HDR_LEN) begin
            finish = 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < 6; i++) begin
          if (fill_eff == 3'(i)) begin
            hw_next[i] = data_byte;
          end
        end
        fill_next = fill_eff + 3'd1;
      end
    end

    // frame completed: count, index every stride-th frame, report
    if (finish) begin
      if (phase == PW'(0) && index_count < ICW'(INDEX_DEPTH)) begin
        idx_we    = 1'b1;
        idx_wdata = pstart_next;
        ic_next   = index_count + ICW'(1);
      end
      if (frame_count != 32'hFFFF_FFFF) begin
        fc_next    = frame_count + 32'd1;
        phase_next = (phase == PW'(INDEX_STRIDE - 1)) ? PW'(0) : phase + PW'(1);
      end
      fill_next   = 3'd0;
      skip_next   = 13'd0;
      rpt.done    = 1'b1;
      rpt.offset  = pstart_next;
      rpt.length  = plen_next;
      rpt.number  = fc_next;
    end

    // new file
    if (clr) begin
      for (int i = 0; i < 6; i++) begin
        hw_next[i] = 8'd0;
      end
      fill_next   = 3'd0;
      skip_next   = 13'd0;
      pstart_next = 32'd0;
      plen_next   = 13'd0;
      bs_next     = 32'd0;
      fc_next     = 32'd0;
      ic_next     = '0;
      phase_next  = '0;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        hw[i] <= 8'd0;
      end
      fill        <= 3'd0;
      skip        <= 13'd0;
      pstart      <= 32'd0;
      plen        <= 13'd0;
      bytes_seen  <= 32'd0;
      frame_count <= 32'd0;
      index_count <= '0;
      phase       <= '0;
    end else begin
      for (int i = 0; i < 6; i++) begin
        hw[i] <= hw_next[i];
      end
      fill        <= fill_next;
      skip        <= skip_next;
      pstart      <= pstart_next;
      plen        <= plen_next;
      bytes_seen  <= bs_next;
      frame_count <= fc_next;
      index_count <= ic_next;
      phase       <= phase_next;
    end
  end

endmodule

>>> hdl/afsi_cdiv.sv
// afsi_cdiv: pipelined unsigned division by a constant, four stages
// reciprocal multiply in two partial products, then one correction step

module afsi_cdiv #(
  parameter int XW  = 42,
  parameter int DIV = 1000
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [XW-1:0]                  x,
  output logic [XW-$clog2(DIV):0]        q
);

  localparam int MW = XW - $clog2(DIV) + 1;
  localparam int XL = XW / 2;
  localparam int XH = XW - XL;
  localparam int RW = $clog2(DIV) + 1;
  localparam int DW = $clog2(DIV + 1);
  localparam logic [MW-1:0] M = MW'((64'd1 << XW) / 64'(DIV));

  logic [XL+MW-1:0] plo;
  logic [XH+MW-1:0] phi;
  logic [RW-1:0]    x1, x2, x3;
  logic [MW-1:0]    q2, q3;
  logic [RW-1:0]    qd3;
  logic [XW+MW-1:0] sum;
  logic [MW+DW-1:0] qd_full;
  logic [RW-1:0]    rem;

  assign sum     = {phi, {XL{1'b0}}} + {{XH{1'b0}}, plo};
  assign qd_full = {{DW{1'b0}}, q2} * {{MW{1'b0}}, DW'(DIV)};
  assign rem     = x3 - qd3;

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products of x times the reciprocal
      plo <= {{MW{1'b0}}, x[XL-1:0]} * {{XL{1'b0}}, M};
      phi <= {{MW{1'b0}}, x[XW-1:XL]} * {{XH{1'b0}}, M};
      x1  <= x[RW-1:0];
      // estimate, low by at most one
      q2  <= sum[XW+MW-1:XW];
      x2  <= x1;
      // low bits of estimate times divisor
      qd3 <= qd_full[RW-1:0];
      q3  <= q2;
      x3  <= x2;
      // correct when the remainder reaches the divisor
      q   <= q3 + MW'(rem >= RW'(DIV));
    end
  end

endmodule

>>> hdl/afsi_index_mem.sv
// afsi_index_mem: frame offset index store, one write and one read port
// read data registered; depends on nothing else

module afsi_index_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/adts_frame_seek_indexer.sv
// adts_frame_seek_indexer: top level, config register, result pipeline
// depends on afsi_pkg, afsi_scan, afsi_cdiv, afsi_index_mem
//
// Scans an ADTS stream one byte per item and takes one item every clock cycle
// unless the pipeline stalls. The scanner state updates in the cycle an item is
// accepted; the index memory is written in that same cycle. Every result (frame
// report or seek answer) then runs through a seven-stage pipeline (snapshot,
// multiply, four stages of constant division, index memory read) and an output
// register that drives result_valid. A waiting result stalls the pipeline only
// when the last stage also holds one. The index memory needs no clearing pass:
// only entries below the fill count are read, and the read comes when its query
// leaves the division stages, before a clear followed by a full frame could
// overwrite it.

module adts_frame_seek_indexer #(
  parameter int INDEX_DEPTH  = 65536,
  parameter int INDEX_STRIDE = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  afsi_pkg::in_t                item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output afsi_pkg::out_t               result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [afsi_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int AW       = $clog2(INDEX_DEPTH);
  localparam int ICW      = $clog2(INDEX_DEPTH + 1);
  localparam int SEEK_DIV = afsi_pkg::PERMIL_FULL * INDEX_STRIDE;
  localparam int QIW      = afsi_pkg::SEEK_PW - $clog2(SEEK_DIV) + 1;
  localparam int QBW      = afsi_pkg::SEEK_PW - $clog2(afsi_pkg::PERMIL_FULL) + 1;
  localparam int QTW      = afsi_pkg::SECS_PW - $clog2(afsi_pkg::US_PER_SEC) + 1;

  // configuration register
  logic [19:0] duration;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == afsi_pkg::REG_FRAME_DURATION);
  assign prdata = (paddr[2] == afsi_pkg::REG_FRAME_DURATION) ? {12'd0, duration} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration <= 20'd0;
    end else if (cfg_wr) begin
      duration <= pwdata[19:0];
    end
  end

  // handshake and pipeline advance
  logic adv;
  logic accept;
  logic v [1:7];

  assign adv        = !v[7] || !result_valid || result_ready;
  assign item_ready = adv;
  assign accept     = item_valid && item_ready;

  // scanner
  afsi_pkg::frame_rpt_t rpt;
  logic            idx_we;
  logic [AW-1:0]   idx_waddr;
  logic [31:0]     idx_wdata;
  logic [31:0]     scan_bs;
  logic [31:0]     scan_fc;
  logic [ICW-1:0]  scan_ic;

  afsi_scan #(
    .INDEX_DEPTH  (INDEX_DEPTH),
    .INDEX_STRIDE (INDEX_STRIDE)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .take        (accept),
    .mode        (item.mode),
    .data_byte   (item.data_byte),
    .rpt         (rpt),
    .idx_we      (idx_we),
    .idx_waddr   (idx_waddr),
    .idx_wdata   (idx_wdata),
    .bytes_seen  (scan_bs),
    .frame_count (scan_fc),
    .index_count (scan_ic)
  );

  // pipeline registers
  afsi_pkg::pipe_t pd [1:7];
  logic [ICW-1:0]  icp [1:6];
  logic [31:0]     bs1;
  logic [9:0]      pm1;
  logic [afsi_pkg::SEEK_PW-1:0] xi2, xb2;
  logic [afsi_pkg::SECS_PW-1:0] xt2;
  logic [QIW-1:0]  qi6;
  logic [QBW-1:0]  qb6;
  logic [QTW-1:0]  qt6;
  logic            ok7;
  logic [31:0]     offb7;
  logic [31:0]     tsec7;
  logic [31:0]     rdata7;
  logic            seek_in;
  logic            res_in;
  afsi_pkg::pipe_t pd_in;

  assign seek_in = item.mode == afsi_pkg::MODE_SEEK;
  assign res_in  = accept && (seek_in || rpt.done);

  // stage one payload: seek snapshot or frame report
  always_comb begin
    if (seek_in) begin
      pd_in.kind         = afsi_pkg::KIND_SEEK;
      pd_in.frame_offset = 32'd0;
      pd_in.frame_length = 13'd0;
      pd_in.frame_number = scan_fc;
    end else begin
      pd_in.kind         = afsi_pkg::KIND_FRAME;
      pd_in.frame_offset = rpt.offset;
      pd_in.frame_length = rpt.length;
      pd_in.frame_number = rpt.number;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 7; i++) begin
        v[i] <= 1'b0;
      end
    end else if (adv) begin
      v[1] <= res_in;
      for (int i = 2; i <= 7; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      pd[1]  <= pd_in;
      icp[1] <= scan_ic;
      bs1    <= scan_bs;
      pm1    <= (item.permil > afsi_pkg::PERMIL_MAX) ? afsi_pkg::PERMIL_MAX : item.permil;
      for (int i = 2; i <= 7; i++) begin
        pd[i] <= pd[i-1];
      end
      for (int i = 2; i <= 6; i++) begin
        icp[i] <= icp[i-1];
      end
      // products for the three quotients
      xi2 <= {10'd0, pd[1].frame_number} * {32'd0, pm1};
      xb2 <= {10'd0, bs1} * {32'd0, pm1};
      xt2 <= {20'd0, pd[1].frame_number} * {32'd0, duration};
      // stage seven: byte fraction offset and saturated seconds
      ok7   <= icp[6] != '0;
      offb7 <= qb6[31:0];
      tsec7 <= (|qt6[QTW-1:32]) ? 32'hFFFF_FFFF : qt6[31:0];
    end
  end

  // constant dividers
  afsi_cdiv #(.XW(afsi_pkg::SEEK_PW), .DIV(SEEK_DIV)) u_div_seek (
    .clk (clk), .en (adv), .x (xi2), .q (qi6)
  );

  afsi_cdiv #(.XW(afsi_pkg::SEEK_PW), .DIV(afsi_pkg::PERMIL_FULL)) u_div_byte (
    .clk (clk), .en (adv), .x (xb2), .q (qb6)
  );

  afsi_cdiv #(.XW(afsi_pkg::SECS_PW), .DIV(afsi_pkg::US_PER_SEC)) u_div_secs (
    .clk (clk), .en (adv), .x (xt2), .q (qt6)
  );

  // index entry, clamped to the last one filled
  logic          past_end;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  assign past_end = {{ICW{1'b0}}, qi6} >= {{QIW{1'b0}}, icp[6]};
  assign rd_addr  = past_end ? AW'(icp[6] - ICW'(1)) : AW'(qi6);
  assign rd_en    = adv && v[6] && (icp[6] != '0);

  afsi_index_mem #(.DEPTH(INDEX_DEPTH), .AW(AW)) u_index_mem (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata7)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && v[7]) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v[7]) begin
      result.kind         <= pd[7].kind;
      result.frame_offset <= pd[7].frame_offset;
      result.frame_length <= pd[7].frame_length;
      result.frame_number <= pd[7].frame_number;
      if (pd[7].kind == afsi_pkg::KIND_SEEK) begin
        result.seek_offset <= ok7 ? rdata7 : offb7;
        result.total_secs  <= tsec7;
      end else begin
        result.seek_offset <= 32'd0;
        result.total_secs  <= 32'd0;
      end
    end
  end

  // checks
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    scan_ic <= ICW'(INDEX_DEPTH))
    else $error("index count beyond index depth");

  a_clear_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && item.mode == afsi_pkg::MODE_CLEAR) |=>
      (scan_fc == 32'd0 && scan_bs == 32'd0 && scan_ic == '0))
    else $error("counters not cleared after clear item");

  a_read_filled: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> ({{(ICW - AW + 1){1'b0}}, rd_addr} < {1'b0, icp[6]}))
    else $error("index read beyond filled entries");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(adv && v[7]))
    else $error("result without a pipeline item");

endmodule
